// ===== rtl/m4vt_pkg.sv =====
`default_nettype none

package m4vt_pkg;

    localparam int DATA_W   = 32;  // Q16.16 word
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int TERM_W   = PROD_W - FRAC_W;
    localparam int SUM_W    = TERM_W + 2;  // four terms summed exactly
    localparam int OUT_ROWS = 4;
    localparam int IDX_W    = 4;

    localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    // stage load enables, one per pipeline register
    typedef struct packed {
        logic load_prod;
        logic load_sum;
        logic load_out;
    } t_pipe_en;

endpackage

`default_nettype wire

// ===== rtl/m4vt_lane.sv =====
`default_nettype none

// One matrix row: registered products, then registered exact sum.
module m4vt_lane #(
    parameter int COLS = 4
) (
    input  wire                                     i_clk,
    input  wire m4vt_pkg::t_pipe_en                 i_en,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_row [COLS],
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_vec [COLS],
    output logic signed [m4vt_pkg::SUM_W-1:0]       o_sum
);
    import m4vt_pkg::*;

    logic signed [PROD_W-1:0] r_prod [COLS];
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;

    always_ff @(posedge i_clk) begin
        if (i_en.load_prod) begin
            for (int c = 0; c < COLS; c++) begin
                r_prod[c] <= i_row[c] * i_vec[c];
            end
        end
    end

    // arithmetic shift gives floor rounding
    always_comb begin
        logic signed [PROD_W-1:0] sh;
        logic signed [TERM_W-1:0] term;
        n_sum = '0;
        for (int c = 0; c < COLS; c++) begin
            sh    = r_prod[c] >>> FRAC_W;
            term  = sh[TERM_W-1:0];
            n_sum = n_sum + SUM_W'(term);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ===== rtl/m4vt_merge.sv =====
`default_nettype none

// Clamps each row sum to 32 bits, ORs the clamp flags, registers the result.
module m4vt_merge #(
    parameter int ROWS = 4
) (
    input  wire                                     i_clk,
    input  wire m4vt_pkg::t_pipe_en                 i_en,
    input  wire logic signed [m4vt_pkg::SUM_W-1:0]  i_sum [ROWS],
    output logic signed [m4vt_pkg::DATA_W-1:0]      o_out [m4vt_pkg::OUT_ROWS],
    output logic                                    o_sat
);
    import m4vt_pkg::*;

    logic signed [DATA_W-1:0] r_out [OUT_ROWS];
    logic                     r_sat;
    logic signed [DATA_W-1:0] n_out [OUT_ROWS];
    logic                     n_sat;

    always_comb begin
        logic [SUM_W-DATA_W:0] hi;
        n_sat = 1'b0;
        for (int r = 0; r < OUT_ROWS; r++) begin
            n_out[r] = '0;
        end
        for (int r = 0; r < ROWS; r++) begin
            hi = i_sum[r][SUM_W-1:DATA_W-1];
            if (hi == '0 || hi == '1) begin
                n_out[r] = i_sum[r][DATA_W-1:0];
            end else begin
                n_out[r] = i_sum[r][SUM_W-1] ? SAT_MIN : SAT_MAX;
                n_sat    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_out) begin
            r_out <= n_out;
            r_sat <= n_sat;
        end
    end

    assign o_out = r_out;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

// ===== rtl/matrix4_vector_transform_core.sv =====
`default_nettype none

// 4x4 matrix times 4-vector, signed Q16.16.
// Input channel: i_valid / o_stall. A transaction is taken at a clock edge with
//   i_valid high and o_stall low. i_operation selects a matrix load
//   (i_entry_index = row*VECTOR_SIZE+col, i_entry_value) or a transform
//   (i_vec_x..i_vec_w). A load gives no result; it applies to the very next
//   transaction.
// Output channel: o_valid / i_stall, one transaction per transform carrying
//   o_out_x..o_out_w and o_saturated (any row clamped to 32 bits).
// Result path: a transform passes the product, row sum and clamp/merge
//   registers in order; o_valid is the valid flag of the last of them.
// Throughput: one transaction per clock while o_stall is low; each row
//   lane has its own multipliers, so sixteen products are formed in parallel.
// Receiver stall: the pipeline holds; empty stages still fill, so o_stall
//   rises only once every stage is occupied and i_stall is high.
// Reset (synchronous, i_rst_n low): matrix returns to identity, pipeline
//   empties, o_valid drops.
module matrix4_vector_transform_core #(
    parameter int VECTOR_SIZE = 4
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire                                  i_operation,
    input  wire [m4vt_pkg::IDX_W-1:0]            i_entry_index,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_entry_value,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_vec_x,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_vec_y,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_vec_z,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_vec_w,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic signed [m4vt_pkg::DATA_W-1:0]   o_out_x,
    output logic signed [m4vt_pkg::DATA_W-1:0]   o_out_y,
    output logic signed [m4vt_pkg::DATA_W-1:0]   o_out_z,
    output logic signed [m4vt_pkg::DATA_W-1:0]   o_out_w,
    output logic                                 o_saturated
);
    import m4vt_pkg::*;

    localparam int ENTRIES   = VECTOR_SIZE * VECTOR_SIZE;
    localparam int MAT_IDX_W = $clog2(ENTRIES);
    // one spare bit so the entry count itself fits for the range check
    localparam int WIDE_W    = ((MAT_IDX_W > IDX_W) ? MAT_IDX_W : IDX_W) + 1;
    // rows and columns that reach the outputs
    localparam int ROWS      = (VECTOR_SIZE < OUT_ROWS) ? VECTOR_SIZE : OUT_ROWS;
    localparam int COLS      = ROWS;

    logic signed [DATA_W-1:0] r_mat [ENTRIES];
    logic                     r_v_prod;
    logic                     r_v_sum;
    logic                     r_v_out;
    t_pipe_en                 en;
    logic                     in_acc;
    logic [WIDE_W-1:0]        wide_idx;
    logic signed [DATA_W-1:0] vec [OUT_ROWS];
    logic signed [SUM_W-1:0]  lane_sum [ROWS];
    logic signed [DATA_W-1:0] merged [OUT_ROWS];

    // Bubble-collapsing enables: a stage loads when it is empty or its
    // successor is moving.
    always_comb begin
        en.load_out  = !r_v_out || !i_stall;
        en.load_sum  = !r_v_sum || en.load_out;
        en.load_prod = !r_v_prod || en.load_sum;
    end
    assign o_stall      = !en.load_prod;
    assign in_acc       = i_valid && en.load_prod;

    assign wide_idx = WIDE_W'(i_entry_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < VECTOR_SIZE; r++) begin
                for (int c = 0; c < VECTOR_SIZE; c++) begin
                    r_mat[MAT_IDX_W'(r * VECTOR_SIZE + c)] <= (r == c) ? ONE_Q16 : '0;
                end
            end
        end else if (in_acc && i_operation == OP_LOAD
                     && wide_idx < WIDE_W'(ENTRIES)) begin
            r_mat[wide_idx[MAT_IDX_W-1:0]] <= i_entry_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (en.load_prod) begin
                r_v_prod <= in_acc && i_operation == OP_XFORM;
            end
            if (en.load_sum) begin
                r_v_sum <= r_v_prod;
            end
            if (en.load_out) begin
                r_v_out <= r_v_sum;
            end
        end
    end

    assign vec[0] = i_vec_x;
    assign vec[1] = i_vec_y;
    assign vec[2] = i_vec_z;
    assign vec[3] = i_vec_w;

    // one lane per output row, each reading its own matrix row
    for (genvar r = 0; r < ROWS; r++) begin : g_lane
        logic signed [DATA_W-1:0] row_ent [COLS];
        logic signed [DATA_W-1:0] row_vec [COLS];
        for (genvar c = 0; c < COLS; c++) begin : g_col
            assign row_ent[c] = r_mat[r * VECTOR_SIZE + c];
            assign row_vec[c] = vec[c];
        end
        m4vt_lane #(
            .COLS (COLS)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_row (row_ent),
            .i_vec (row_vec),
            .o_sum (lane_sum[r])
        );
    end

    m4vt_merge #(
        .ROWS (ROWS)
    ) u_merge (
        .i_clk (i_clk),
        .i_en  (en),
        .i_sum (lane_sum),
        .o_out (merged),
        .o_sat (o_saturated)
    );

    assign o_valid = r_v_out;
    assign o_out_x = merged[0];
    assign o_out_y = merged[1];
    assign o_out_z = merged[2];
    assign o_out_w = merged[3];

`ifndef SYNTHESIS
    // a clamp flag must come with at least one clamped component
    a_sat_has_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            (o_out_x == SAT_MAX || o_out_x == SAT_MIN ||
             o_out_y == SAT_MAX || o_out_y == SAT_MIN ||
             o_out_z == SAT_MAX || o_out_z == SAT_MIN ||
             o_out_w == SAT_MAX || o_out_w == SAT_MIN))
        else $error("saturated set with no clamped component");

    // a matrix load never enters the arithmetic pipeline
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_operation == OP_LOAD |=> !r_v_prod)
        else $error("load transaction entered the pipeline");

    // reset restores the identity matrix (checked on entry 0) and clears o_valid
    a_reset_identity: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> r_mat[0] == ONE_Q16 && !o_valid)
        else $error("matrix not identity after reset");
`endif

endmodule

`default_nettype wire

// ===== verif/m4vt_result_checker.sv =====
`default_nettype none

// Watches both channels of the transform core, keeps its own copy of the
// matrix, predicts each transform result and compares it field by field.
module m4vt_result_checker #(
    parameter int VECTOR_SIZE = 4
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    input  wire                       i_in_stall,
    input  wire                       i_operation,
    input  wire [m4vt_pkg::IDX_W-1:0] i_entry_index,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_entry_value,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_vec_x,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_vec_y,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_vec_z,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_vec_w,
    input  wire                       i_out_valid,
    input  wire                       i_out_stall,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_out_x,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_out_y,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_out_z,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] i_out_w,
    input  wire                       i_saturated,
    output int                        o_pending,
    output int                        o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import m4vt_pkg::*;

    localparam int ENTRIES = VECTOR_SIZE * VECTOR_SIZE;
    localparam int USED    = (VECTOR_SIZE < OUT_ROWS) ? VECTOR_SIZE : OUT_ROWS;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic signed [DATA_W-1:0] out_w;
        logic                     saturated;
    } t_vertex;

    logic signed [DATA_W-1:0] coeff [ENTRIES];
    t_vertex                  pending_vertices [$];
    int                       mismatches = 0;

    // floor-rounded Q16.16 products, exact row sum, clamp to 32 bits
    function automatic t_vertex transform_vertex(input logic signed [DATA_W-1:0] vx,
                                                 input logic signed [DATA_W-1:0] vy,
                                                 input logic signed [DATA_W-1:0] vz,
                                                 input logic signed [DATA_W-1:0] vw);
        t_vertex                  res;
        logic signed [DATA_W-1:0] comp [OUT_ROWS];
        logic signed [DATA_W-1:0] row_out [OUT_ROWS];
        longint                   acc;
        comp[0] = vx;
        comp[1] = vy;
        comp[2] = vz;
        comp[3] = vw;
        res.saturated = 1'b0;
        for (int r = 0; r < OUT_ROWS; r++) begin
            row_out[r] = '0;
        end
        for (int r = 0; r < USED; r++) begin
            acc = 0;
            for (int c = 0; c < USED; c++) begin
                acc += (longint'(coeff[r*VECTOR_SIZE+c]) * longint'(comp[c])) >>> FRAC_W;
            end
            if (acc > longint'(SAT_MAX)) begin
                row_out[r] = SAT_MAX;
                res.saturated = 1'b1;
            end else if (acc < longint'(SAT_MIN)) begin
                row_out[r] = SAT_MIN;
                res.saturated = 1'b1;
            end else begin
                row_out[r] = acc[DATA_W-1:0];
            end
        end
        res.out_x = row_out[0];
        res.out_y = row_out[1];
        res.out_z = row_out[2];
        res.out_w = row_out[3];
        return res;
    endfunction

    task automatic check_field(input string name, input logic signed [DATA_W-1:0] want,
                               input logic signed [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_vertex want;
        if (!i_rst_n) begin
            for (int k = 0; k < ENTRIES; k++) begin
                coeff[k] = (k / VECTOR_SIZE == k % VECTOR_SIZE) ? ONE_Q16 : '0;
            end
            pending_vertices.delete();
        end else begin
            // results first, so a stray output never pairs with a same-cycle input
            if (i_out_valid && !i_out_stall) begin
                if (pending_vertices.size() == 0) begin
                    $error("result transaction with no transform outstanding");
                    mismatches++;
                end else begin
                    want = pending_vertices.pop_front();
                    check_field("out_x", want.out_x, i_out_x);
                    check_field("out_y", want.out_y, i_out_y);
                    check_field("out_z", want.out_z, i_out_z);
                    check_field("out_w", want.out_w, i_out_w);
                    check_field("saturated", DATA_W'(want.saturated), DATA_W'(i_saturated));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_operation == OP_XFORM) begin
                    pending_vertices.push_back(transform_vertex(i_vec_x, i_vec_y,
                                                                i_vec_z, i_vec_w));
                end else if (int'(i_entry_index) < ENTRIES) begin
                    coeff[i_entry_index] = i_entry_value;
                end
            end
        end
        o_pending <= pending_vertices.size();
        o_errors  <= mismatches;
    end

endmodule

`default_nettype wire

// ===== verif/tb_matrix4_vector_transform_core.sv =====
`default_nettype none

// Top of the transform core testbench.
// Stimulus only: a directed opener covering identity, zero, clamping in both
// directions and floor rounding of negative products, then a reload of every
// matrix entry, then a random mix of loads and transforms. The checker beside
// the core does all prediction and comparison and reports its counts here.
module tb_matrix4_vector_transform_core;
    timeunit 1ns;
    timeprecision 1ps;

    import m4vt_pkg::*;

    localparam int RANDOM_ITEMS = 650;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int DRAIN_TAIL   = 10;    // well past the product, sum and output registers

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     i_operation = OP_LOAD;
    logic [IDX_W-1:0]         i_entry_index = '0;
    logic signed [DATA_W-1:0] i_entry_value = '0;
    logic signed [DATA_W-1:0] i_vec_x = '0;
    logic signed [DATA_W-1:0] i_vec_y = '0;
    logic signed [DATA_W-1:0] i_vec_z = '0;
    logic signed [DATA_W-1:0] i_vec_w = '0;
    logic                     i_stall = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_out_x;
    logic signed [DATA_W-1:0] o_out_y;
    logic signed [DATA_W-1:0] o_out_z;
    logic signed [DATA_W-1:0] o_out_w;
    logic                     o_saturated;

    int pending;
    int errors;
    int idle_cycles = 0;
    int send_gap_max = 10;   // upper bound of the per-transaction sender gap
    int sink_stall_max = 10; // upper bound of the per-result receiver stall

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    matrix4_vector_transform_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_vec_x       (i_vec_x),
        .i_vec_y       (i_vec_y),
        .i_vec_z       (i_vec_z),
        .i_vec_w       (i_vec_w),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_out_w       (o_out_w),
        .o_saturated   (o_saturated)
    );

    m4vt_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_vec_x       (i_vec_x),
        .i_vec_y       (i_vec_y),
        .i_vec_z       (i_vec_z),
        .i_vec_w       (i_vec_w),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_x       (o_out_x),
        .i_out_y       (o_out_y),
        .i_out_z       (o_out_z),
        .i_out_w       (o_out_w),
        .i_saturated   (o_saturated),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    // Operand mix: clamp extremes, zero, full-range noise, and small values
    // (about +/-16.0) that keep row sums in range so exact results get checked.
    function automatic logic signed [DATA_W-1:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return '0;
            3: return ONE_Q16;
            4, 5: return $urandom;
            default: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    // One input transaction: random gap with valid low, then hold the
    // payload until the core takes it. Returns at the accepting edge.
    task automatic drive_transaction(input logic op, input logic [IDX_W-1:0] idx,
                                     input logic signed [DATA_W-1:0] val,
                                     input logic signed [DATA_W-1:0] vx,
                                     input logic signed [DATA_W-1:0] vy,
                                     input logic signed [DATA_W-1:0] vz,
                                     input logic signed [DATA_W-1:0] vw);
        int gap;
        gap = $urandom_range(send_gap_max);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_entry_index <= idx;
        i_entry_value <= val;
        i_vec_x       <= vx;
        i_vec_y       <= vy;
        i_vec_z       <= vz;
        i_vec_w       <= vw;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
    endtask

    // vector fields of a load are don't-care, so they carry noise
    task automatic load_entry(input logic [IDX_W-1:0] idx,
                              input logic signed [DATA_W-1:0] val);
        drive_transaction(OP_LOAD, idx, val, $urandom, $urandom, $urandom, $urandom);
    endtask

    // entry fields of a transform are don't-care as well
    task automatic send_vector(input logic signed [DATA_W-1:0] vx,
                               input logic signed [DATA_W-1:0] vy,
                               input logic signed [DATA_W-1:0] vz,
                               input logic signed [DATA_W-1:0] vw);
        drive_transaction(OP_XFORM, IDX_W'($urandom), $urandom, vx, vy, vz, vw);
    endtask

    // Drop valid and wait until every outstanding transform has come back.
    // Always advances at least one edge so valid is not re-raised in the same step.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Receiver: per result, stall for a drawn number of cycles, then take it.
    // Every 40 results it may switch to a no-stall stretch.
    initial begin : result_sink
        int hold;
        int taken;
        taken = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 40 == 0) begin
                sink_stall_max = ($urandom_range(3) == 0) ? 0 : 10;
            end
            hold = $urandom_range(sink_stall_max);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            taken++;
        end
    end

    // Watchdog: a stuck handshake on either side ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity after reset passes the vector through unchanged
        send_vector(SAT_MAX, SAT_MIN, '0, 32'shFFFF_FFFF);
        send_vector('0, '0, '0, '0);

        // extreme coefficients: positive and negative clamping,
        // min times min, and a -1 LSB entry for floor rounding
        load_entry(4'd0, SAT_MAX);
        load_entry(4'd5, SAT_MIN);
        load_entry(4'd10, SAT_MIN);
        load_entry(4'd15, 32'shFFFF_FFFF);
        send_vector(SAT_MAX, SAT_MAX, SAT_MIN, 32'sd1);
        send_vector(32'sd1, 32'shFFFF_FFFF, 32'sd1, 32'shFFFF_FFFF);

        // rewrite every entry in row-major order, half-unit steps around zero
        for (int k = 0; k < 16; k++) begin
            load_entry(IDX_W'(k), (k - 8) * 32'sh0000_8000);
        end
        send_vector(ONE_Q16, -ONE_Q16, 32'sh0003_8000, 32'shFFFF_0001);

        // random mix; sender idling switches between busy and quiet stretches
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                send_gap_max = ($urandom_range(3) == 0) ? 0 : 10;
            end
            if (n % 160 == 80) begin
                drain_results();
            end
            if ($urandom_range(9) < 4) begin
                load_entry(IDX_W'($urandom_range(15)), pick_word());
            end else begin
                send_vector(pick_word(), pick_word(), pick_word(), pick_word());
            end
        end

        drain_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
